[rtl/legendre_basis_evaluator_top_macros.svh]
// Assertion macros shared by the Legendre basis evaluator modules
`ifndef LEGENDRE_BASIS_EVALUATOR_TOP_MACROS_SVH
`define LEGENDRE_BASIS_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LBE_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LBE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LBE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LBE_ASSERT(lbl, clk, rst, cond, msg)
`define LBE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LBE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/lbe_pkg.sv]
// Types, constants and tables of the Legendre basis evaluator
`timescale 1ns / 1ps
`default_nettype none
package lbe_pkg;

  localparam int COORD_W   = 32;
  localparam int VAL_W     = 32;
  localparam int ORD_W     = 4;
  localparam int MAX_ORDER = 15;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 31;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [VAL_W-1:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam logic [2:0] REG_X_LOW      = 3'd0;
  localparam logic [2:0] REG_X_HIGH     = 3'd1;
  localparam logic [2:0] REG_Y_LOW      = 3'd2;
  localparam logic [2:0] REG_Y_HIGH     = 3'd3;
  localparam logic [2:0] REG_POLY_ORDER = 3'd4;

  // round(2^30 / i); orders zero and one never use it
  localparam logic [29:0] RECIP [0:MAX_ORDER] = '{
    30'd0,         30'd0,         30'd536870912, 30'd357913941,
    30'd268435456, 30'd214748365, 30'd178956971, 30'd153391689,
    30'd134217728, 30'd119304647, 30'd107374182, 30'd97612893,
    30'd89478485,  30'd82595525,  30'd76695845,  30'd71582788
  };

  typedef struct packed {
    logic                    err;
    logic signed [VAL_W-1:0] u;
    logic [ORD_W-1:0]        n;
  } lbe_item_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHK,
    F_LOAD,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EMIT,
    B_MUL,
    B_RND,
    B_SUM,
    B_PLO,
    B_PHI,
    B_FIN
  } back_state_t;

endpackage
`default_nettype wire

[rtl/lbe_front.sv]
// Front end: bounds check and mapping of the coordinate onto [-1,1]
`timescale 1ns / 1ps
`default_nettype none
`include "legendre_basis_evaluator_top_macros.svh"
module lbe_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [lbe_pkg::COORD_W-1:0] coordinate,
  input  wire logic                            use_y_axis,
  input  wire logic signed [lbe_pkg::COORD_W-1:0] x_low,
  input  wire logic signed [lbe_pkg::COORD_W-1:0] x_high,
  input  wire logic signed [lbe_pkg::COORD_W-1:0] y_low,
  input  wire logic signed [lbe_pkg::COORD_W-1:0] y_high,
  input  wire logic [lbe_pkg::ORD_W-1:0]       poly_order,
  output logic                                 q_wr,
  output lbe_pkg::lbe_item_t                   q_data,
  input  wire logic                            q_full
);
  import lbe_pkg::*;

  front_state_t state, state_next;

  logic signed [COORD_W-1:0] c_r, lo_r, hi_r;
  logic [ORD_W-1:0]          n_r;
  logic                      err_r;
  logic signed [COORD_W+1:0] num_r;
  logic [COORD_W-1:0]        den;
  logic [COORD_W-1:0]        rem;
  logic [DIV_STEPS-1:0]      dlow;
  logic [DIV_STEPS-1:0]      quo;
  logic [CNT_W-1:0]          cnt;

  logic                      accept;
  logic                      err_chk;
  logic signed [COORD_W+1:0] num_chk;
  logic signed [COORD_W:0]   den_chk;
  logic [COORD_W+1:0]        num_abs;
  logic [62:0]               dividend;
  logic [COORD_W:0]          trial;
  logic                      qbit;
  logic [VAL_W-1:0]          u_val;

  assign accept = push && !full;

  assign err_chk = (hi_r <= lo_r) || (c_r < lo_r) || (c_r > hi_r);
  assign num_chk = (COORD_W+2)'(c_r) + (COORD_W+2)'(c_r) - (COORD_W+2)'(lo_r)
                 - (COORD_W+2)'(hi_r);
  assign den_chk = (COORD_W+1)'(hi_r) - (COORD_W+1)'(lo_r);

  assign num_abs  = num_r[COORD_W+1] ? (COORD_W+2)'(-num_r) : num_r;
  assign dividend = {1'b0, num_abs[COORD_W-1:0], 30'd0} + {32'd0, den[COORD_W-1:1]};

  assign trial = {rem, dlow[DIV_STEPS-1]};
  assign qbit  = (trial >= {1'b0, den});

  assign u_val = num_r[COORD_W+1] ? (32'd0 - {1'b0, quo}) : {1'b0, quo};

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_CHK;
      F_CHK:  state_next = err_chk ? F_PUSH : F_LOAD;
      F_LOAD: state_next = F_DIV;
      F_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_wr   = (state == F_PUSH) && !q_full;
    q_data = '{err: err_r, u: err_r ? '0 : u_val, n: n_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          c_r  <= coordinate;
          lo_r <= use_y_axis ? y_low : x_low;
          hi_r <= use_y_axis ? y_high : x_high;
          n_r  <= (poly_order > MAX_ORDER) ? ORD_W'(MAX_ORDER) : poly_order;
        end
      end
      F_CHK: begin
        err_r <= err_chk;
        num_r <= num_chk;
        den   <= den_chk[COORD_W-1:0];
      end
      F_LOAD: begin
        rem  <= dividend[62:DIV_STEPS];
        dlow <= dividend[DIV_STEPS-1:0];
        quo  <= '0;
        cnt  <= '0;
      end
      F_DIV: begin
        rem  <= qbit ? COORD_W'(trial - {1'b0, den}) : trial[COORD_W-1:0];
        dlow <= {dlow[DIV_STEPS-2:0], 1'b0};
        quo  <= {quo[DIV_STEPS-2:0], qbit};
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `LBE_ASSERT_NXT(a_accept_chk, clk, rst, accept, state == F_CHK, "accepted item not checked")
  `LBE_ASSERT_IMP(a_div_rem, clk, rst, state == F_DIV, rem < den, "remainder not below divisor")
  `LBE_ASSERT_IMP(a_u_bound, clk, rst, q_wr && !err_r, quo <= DIV_STEPS'(ONE_Q30), "u beyond one")

endmodule
`default_nettype wire

[rtl/lbe_queue.sv]
// Short queue of mapped coordinates between front and back
`timescale 1ns / 1ps
`default_nettype none
module lbe_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire lbe_pkg::lbe_item_t wr_data,
  output logic                    full,
  input  wire logic               rd_en,
  output lbe_pkg::lbe_item_t      rd_data,
  output logic                    empty
);
  import lbe_pkg::*;

  lbe_item_t         mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[rtl/lbe_back.sv]
// Back end: three-term recurrence and result register
`timescale 1ns / 1ps
`default_nettype none
`include "legendre_basis_evaluator_top_macros.svh"
module lbe_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_empty,
  output logic                                  q_rd,
  input  wire lbe_pkg::lbe_item_t               q_data,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic signed [lbe_pkg::VAL_W-1:0]      poly_value,
  output logic [lbe_pkg::ORD_W-1:0]             term_index,
  output logic                                  range_error,
  output logic                                  last_term
);
  import lbe_pkg::*;

  back_state_t state, state_next;

  logic                    out_valid;
  logic signed [VAL_W-1:0] u, cur_val, pm1, pm2;
  logic [ORD_W-1:0]        n, idx;
  logic                    err;
  logic                    tneg;
  logic [62:0]             prod;
  logic signed [32:0]      t;
  logic signed [39:0]      s;
  logic                    sneg;
  logic [39:0]             smag;
  logic [49:0]             plo, phi;

  logic                    slot_free;
  logic                    emit;
  logic                    last;
  logic [30:0]             umag;
  logic [31:0]             pmag;
  logic [62:0]             tsum;
  logic [32:0]             tm;
  logic [4:0]              k1;
  logic [ORD_W-1:0]        k2;
  logic signed [38:0]      a_term;
  logic signed [36:0]      b_term;
  logic [39:0]             smag_next;
  logic [69:0]             full_sum;
  logic [69:0]             rsum;
  logic [39:0]             rmag;
  logic [VAL_W-1:0]        p_sat;

  assign slot_free = !out_valid || pop;
  assign last      = err || (idx == n);

  assign umag = u[VAL_W-1] ? 31'(32'd0 - u) : u[30:0];
  assign pmag = pm1[VAL_W-1] ? (32'd0 - pm1) : pm1;

  assign tsum = prod + 63'(1 << 29);
  assign tm   = tsum[62:30];

  assign k1     = {idx, 1'b0} - 5'd1;
  assign k2     = idx - 1'b1;
  assign a_term = 39'($signed({1'b0, k1})) * 39'(t);
  assign b_term = 37'($signed({1'b0, k2})) * 37'(pm2);

  assign smag_next = s[39] ? 40'(-s) : s;

  assign full_sum = {20'd0, plo} + {phi, 20'd0};
  assign rsum     = full_sum + 70'(1 << 29);
  assign rmag     = rsum[69:30];

  always_comb begin
    if (!sneg) begin
      p_sat = (rmag > 40'(SAT_MAX)) ? SAT_MAX : rmag[VAL_W-1:0];
    end else begin
      p_sat = (rmag > 40'(SAT_MIN)) ? SAT_MIN : (32'd0 - rmag[VAL_W-1:0]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_empty) state_next = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          if (last) begin
            state_next = B_IDLE;
          end else if (idx != '0) begin
            state_next = B_MUL;
          end
        end
      end
      B_MUL: state_next = B_RND;
      B_RND: state_next = B_SUM;
      B_SUM: state_next = B_PLO;
      B_PLO: state_next = B_PHI;
      B_PHI: state_next = B_FIN;
      B_FIN: state_next = B_EMIT;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_rd  = (state == B_IDLE) && !q_empty;
    emit  = (state == B_EMIT) && slot_free;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      poly_value  <= err ? '0 : cur_val;
      term_index  <= idx;
      range_error <= err;
      last_term   <= last;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_rd) begin
          u       <= q_data.u;
          n       <= q_data.n;
          err     <= q_data.err;
          idx     <= '0;
          cur_val <= ONE_Q30;
          pm1     <= ONE_Q30;
          pm2     <= '0;
        end
      end
      B_EMIT: begin
        if (slot_free && !last) begin
          idx <= idx + 1'b1;
          if (idx == '0) begin
            cur_val <= u;
          end else begin
            pm2 <= pm1;
            pm1 <= cur_val;
          end
        end
      end
      B_MUL: begin
        prod <= 63'(umag) * 63'(pmag);
        tneg <= u[VAL_W-1] ^ pm1[VAL_W-1];
      end
      B_RND: begin
        t <= tneg ? -$signed(tm) : $signed(tm);
      end
      B_SUM: begin
        s <= 40'(a_term) - 40'(b_term);
      end
      B_PLO: begin
        smag <= smag_next;
        sneg <= s[39];
        plo  <= 50'(smag_next[19:0]) * 50'(RECIP[idx]);
      end
      B_PHI: begin
        phi <= 50'(smag[39:20]) * 50'(RECIP[idx]);
      end
      B_FIN: begin
        cur_val <= p_sat;
      end
      default: begin
      end
    endcase
  end

  `LBE_ASSERT_NXT(a_last_idle, clk, rst, emit && last, state == B_IDLE, "no return to idle")
  `LBE_ASSERT(a_err_shape, clk, rst, !out_valid || !range_error || (last_term && poly_value == 0 && term_index == 0), "malformed error result")
  `LBE_ASSERT_IMP(a_idx_bound, clk, rst, state != B_IDLE, idx <= n, "order beyond limit")

endmodule
`default_nettype wire

[rtl/legendre_basis_evaluator_top.sv]
// Top level of the Legendre basis evaluator: register file, front, queue, back
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | push / full          | coordinate, use_y_axis
//  result   | pop / empty          | poly_value, term_index, range_error, last_term
//  config   | psel penable pwrite  | paddr, pwdata, prdata (pready tied high)
//
//  Front: bounds check, mapping and a 31-step restoring divider; full stays high
//  until the item is pushed, and an out-of-bounds item skips the divider.
//  Back: each order from two up takes the steps MUL, RND, SUM, PLO, PHI and FIN
//  before its term is emitted; orders zero and one and an error skip them.
//  Sustained rate is the slower of the two; a two-entry queue lets them overlap.
//  Reset is synchronous: registers return to their defaults, queue and result empty.
//  A held-off pop stalls the back only; the front keeps filling the queue until it is full.
`timescale 1ns / 1ps
`default_nettype none
module legendre_basis_evaluator_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lbe_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [lbe_pkg::DATA_W-1:0]          pwdata,
  output logic [lbe_pkg::DATA_W-1:0]               prdata,
  output logic                                     pready,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [lbe_pkg::COORD_W-1:0]  coordinate,
  input  wire logic                                use_y_axis,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [lbe_pkg::VAL_W-1:0]         poly_value,
  output logic [lbe_pkg::ORD_W-1:0]                term_index,
  output logic                                     range_error,
  output logic                                     last_term
);
  import lbe_pkg::*;

  logic signed [COORD_W-1:0] x_low, x_high, y_low, y_high;
  logic [ORD_W-1:0]          poly_order;
  logic                      cfg_wr;
  logic [2:0]                reg_sel;

  logic                      q_wr, q_rd, q_full, q_empty;
  lbe_item_t                 q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low      <= -32'sd65536;
      x_high     <= 32'sd65536;
      y_low      <= -32'sd65536;
      y_high     <= 32'sd65536;
      poly_order <= 4'd3;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_X_LOW:      x_low      <= pwdata;
        REG_X_HIGH:     x_high     <= pwdata;
        REG_Y_LOW:      y_low      <= pwdata;
        REG_Y_HIGH:     y_high     <= pwdata;
        REG_POLY_ORDER: poly_order <= pwdata[ORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_X_LOW:      prdata = x_low;
      REG_X_HIGH:     prdata = x_high;
      REG_Y_LOW:      prdata = y_low;
      REG_Y_HIGH:     prdata = y_high;
      REG_POLY_ORDER: prdata = DATA_W'(poly_order);
      default:        prdata = '0;
    endcase
  end

  lbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .coordinate (coordinate),
    .use_y_axis (use_y_axis),
    .x_low      (x_low),
    .x_high     (x_high),
    .y_low      (y_low),
    .y_high     (y_high),
    .poly_order (poly_order),
    .q_wr       (q_wr),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  lbe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .q_data      (q_rdata),
    .pop         (pop),
    .empty       (empty),
    .poly_value  (poly_value),
    .term_index  (term_index),
    .range_error (range_error),
    .last_term   (last_term)
  );

endmodule
`default_nettype wire
